[hdl/pt_rtt_pkg.sv]
// Shared types and constants for the Pt100 resistance to temperature pipeline.
// No dependencies; imported by every module of the block.
package pt_rtt_pkg;

  // Port widths
  localparam int IN_W  = 19;
  localparam int OUT_W = 19;

  // Default fixed-point formats
  localparam int DEF_RES_FRAC_BITS  = 10;
  localparam int DEF_TEMP_FRAC_BITS = 8;

  // Datapath widths
  localparam int SQ_W       = 64;  // radicand
  localparam int ROOT_W     = 32;  // root, also the number of sqrt steps
  localparam int SQRT_SHIFT = 26;  // radicand is scaled to 26 fraction bits
  localparam int ROOT_FRAC  = 13;  // root fraction bits
  localparam int DIFF_W     = 24;  // 100 ohm minus resistance, signed
  localparam int PROD_W     = 53;  // 4B times the difference, signed
  localparam int N_W        = 34;  // A minus root, signed
  localparam int MAG_W      = 30;  // magnitude of that over the valid span

  // Curve constants, scaled to integers
  localparam int                R0_OHMS       = 100;
  localparam logic [63:0]       A_SCALED      = 64'd390802;        // A * 1e8
  localparam logic [63:0]       A_SQUARED     = 64'd152726203204;  // (A * 1e8)^2
  localparam logic signed [28:0] FOUR_B_SCALED = 29'sd232080000;    // 4B * 1e16 / 100
  localparam logic [13:0]       TWO_B_SCALED  = 14'd11604;         // 2B * 1e10
  localparam logic [63:0]       LOW_MILLIOHM  = 64'd20545;
  localparam logic [63:0]       HIGH_MILLIOHM = 64'd390524;

  // Control that travels alongside each pipeline word
  typedef struct packed {
    logic valid;
    logic oor;
  } pt_rtt_ctl_t;

endpackage

[hdl/pt_rtt_front.sv]
// Front end: span check, radicand 4B*(100-R) product and A^2 offset, two stages.
// Depends on pt_rtt_pkg.
module pt_rtt_front import pt_rtt_pkg::*; #(
  parameter int RES_FRAC_BITS = DEF_RES_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [IN_W-1:0]    resistance_i,
  output logic [SQ_W-1:0]    m_o,
  output pt_rtt_ctl_t        ctl_o
);

  localparam logic [31:0] LO_BOUND =
    32'((LOW_MILLIOHM * (64'd1 << RES_FRAC_BITS) + 64'd999) / 64'd1000);
  localparam logic [31:0] HI_BOUND =
    32'((HIGH_MILLIOHM * (64'd1 << RES_FRAC_BITS)) / 64'd1000);
  localparam logic [DIFF_W-1:0] HUNDRED_SCALED = DIFF_W'(R0_OHMS << RES_FRAC_BITS);
  localparam logic [SQ_W-1:0]   A_SQ_SCALED    = A_SQUARED << RES_FRAC_BITS;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     oor;
  pt_rtt_ctl_t              ctl1_d, ctl1_q, ctl2_q;
  logic [SQ_W-1:0]          d_sum, m_d, m_q;

  // stage 1: span check and the one wide product
  always_comb begin
    oor    = (32'(resistance_i) < LO_BOUND) || (32'(resistance_i) > HI_BOUND);
    diff   = $signed(HUNDRED_SCALED) - $signed(DIFF_W'(resistance_i));
    prod_d = PROD_W'(FOUR_B_SCALED) * PROD_W'(diff);
    ctl1_d = '{valid: valid_i, oor: oor};
  end

  // stage 2: add A^2 and align to the radicand scale (positive over the span)
  always_comb begin
    d_sum = A_SQ_SCALED + SQ_W'(prod_q);
    m_d   = d_sum << (SQRT_SHIFT - RES_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      m_q    <= m_d;
    end
  end

  assign m_o   = m_q;
  assign ctl_o = ctl2_q;

endmodule

[hdl/pt_rtt_sqrt.sv]
// Pipelined restoring integer square root, one result bit per register stage.
// Depends on pt_rtt_pkg.
module pt_rtt_sqrt import pt_rtt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [SQ_W-1:0]    m_i,
  input  pt_rtt_ctl_t        ctl_i,
  output logic [ROOT_W-1:0]  root_o,
  output pt_rtt_ctl_t        ctl_o
);

  logic [SQ_W-1:0] rem_q  [ROOT_W];
  logic [SQ_W-1:0] root_q [ROOT_W];
  pt_rtt_ctl_t     ctl_q  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);

    logic [SQ_W-1:0] rem_in, root_in, trial, rem_d, root_d;
    pt_rtt_ctl_t     ctl_in;

    if (i == 0) begin : g_first
      assign rem_in  = m_i;
      assign root_in = '0;
      assign ctl_in  = ctl_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign ctl_in  = ctl_q[i-1];
    end

    always_comb begin
      trial = root_in + STEP_BIT;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + STEP_BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        root_q[i] <= root_d;
      end
    end
  end

  assign root_o = root_q[ROOT_W-1][ROOT_W-1:0];
  assign ctl_o  = ctl_q[ROOT_W-1];

  // remainder m - s^2 never exceeds 2s once all bits are settled
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[ROOT_W-1].valid |-> rem_q[ROOT_W-1] <= (root_q[ROOT_W-1] << 1))
    else $error("sqrt remainder above 2*root");

  a_root_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[ROOT_W-1].valid |-> root_q[ROOT_W-1][SQ_W-1:ROOT_W] == '0)
    else $error("sqrt root wider than its field");

endmodule

[hdl/pt_rtt_back.sv]
// Back end: A minus root, rounded division by the 2B constant, sign and saturation.
// Four register stages; the last one drives the result combinationally. Uses pt_rtt_pkg.
module pt_rtt_back import pt_rtt_pkg::*; #(
  parameter int TEMP_FRAC_BITS = DEF_TEMP_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic [ROOT_W-1:0]       root_i,
  input  pt_rtt_ctl_t             ctl_i,
  output logic signed [OUT_W-1:0] temperature_o,
  output pt_rtt_ctl_t             ctl_o
);

  localparam int PW = MAG_W + 7;                                // mag * 100
  localparam int YW = PW - (ROOT_FRAC - TEMP_FRAC_BITS) + 1;    // dividend
  localparam int QW = YW - ROOT_FRAC;                           // quotient
  localparam int TW = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;

  localparam logic [N_W-1:0]       N_BASE    = N_W'(A_SCALED << ROOT_FRAC);
  localparam logic [YW-1:0]        DEN_HALF  = YW'(TWO_B_SCALED >> 1);
  localparam logic [YW-1:0]        RECIP     = YW'((64'd1 << YW) / 64'(TWO_B_SCALED));
  localparam logic signed [TW-1:0] T_MAX     = TW'((1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [TW-1:0] T_MIN     = ~T_MAX;

  pt_rtt_ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;

  logic [N_W-1:0]    n_diff, n_abs;
  logic              neg_d;
  logic [MAG_W-1:0]  mag_d, mag_q;
  logic [PW-1:0]     mag100, mag_scaled;
  logic [YW-1:0]     y_d, y_q;
  logic [2*YW-1:0]   qprod;
  logic [QW-1:0]     qest_d, qest_q, q_d, q_q;
  logic [15:0]       ylo_q, rem;
  logic              inc;
  logic signed [TW-1:0] t_mag, t_full, t_sat;

  // stage 1: N = A*2^13 - s and its magnitude
  always_comb begin
    n_diff = N_BASE - N_W'(root_i);
    neg_d  = n_diff[N_W-1];
    n_abs  = neg_d ? (N_W'(0) - n_diff) : n_diff;
    mag_d  = n_abs[MAG_W-1:0];
  end

  // stage 2: dividend with the 2^13 of the divisor taken off and half the divisor added
  always_comb begin
    mag100     = PW'(mag_q) * PW'(R0_OHMS);
    mag_scaled = mag100 >> (ROOT_FRAC - TEMP_FRAC_BITS);
    y_d        = YW'(mag_scaled) + DEN_HALF;
  end

  // stage 3: reciprocal estimate, low by at most one
  always_comb begin
    qprod  = (2 * YW)'(y_q) * (2 * YW)'(RECIP);
    qest_d = qprod[YW+QW-1:YW];
  end

  // stage 4: remainder is below twice the divisor, so 16 bits hold it exactly
  always_comb begin
    rem   = ylo_q - 16'(32'(qest_q) * 32'(TWO_B_SCALED));
    inc   = rem >= 16'(TWO_B_SCALED);
    q_d   = qest_q + QW'(inc);
  end

  // output: sign, saturate, zero when out of span
  always_comb begin
    t_mag  = $signed(TW'(q_q));
    t_full = neg4_q ? -t_mag : t_mag;
    if (t_full > T_MAX) begin
      t_sat = T_MAX;
    end else if (t_full < T_MIN) begin
      t_sat = T_MIN;
    end else begin
      t_sat = t_full;
    end
    temperature_o = ctl4_q.oor ? '0 : OUT_W'(t_sat);
  end

  assign ctl_o = ctl4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg_d;
      mag_q  <= mag_d;
      neg2_q <= neg1_q;
      y_q    <= y_d;
      neg3_q <= neg2_q;
      qest_q <= qest_d;
      ylo_q  <= y_q[15:0];
      neg4_q <= neg3_q;
      q_q    <= q_d;
    end
  end

  a_one_correction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl3_q.valid |-> rem < 16'(2 * TWO_B_SCALED))
    else $error("quotient estimate off by more than one");

endmodule

[hdl/pt100_resistance_to_temperature_top.sv]
// Top level of the Pt100 resistance to temperature converter.
// Instantiates pt_rtt_front, pt_rtt_sqrt and pt_rtt_back; uses pt_rtt_pkg.

// One word in and one word out per cycle while nothing stalls. A word passes 39
// registers: 2 front stages, 32 square root stages (one root bit each, the
// bulk of the latency), 4 division and rounding stages and the output
// register. A single skid register behind the output lets the pipeline keep
// moving for one more word while a result waits; the input stalls only while
// that skid register is full. Resistances outside 20.545 to 390.524 ohms give
// temperature 0 with out_of_range set.
module pt100_resistance_to_temperature_top import pt_rtt_pkg::*; #(
  parameter int RES_FRAC_BITS  = DEF_RES_FRAC_BITS,
  parameter int TEMP_FRAC_BITS = DEF_TEMP_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IN_W-1:0]         resistance_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] temperature_o,
  output logic                    out_of_range_o
);

  logic                    pipe_en;
  logic [SQ_W-1:0]         m;
  pt_rtt_ctl_t             front_ctl, sqrt_ctl, res_ctl;
  logic [ROOT_W-1:0]       root;
  logic signed [OUT_W-1:0] res_temp;
  logic                    res_push;

  logic                    out_valid_d, out_valid_q, out_oor_d, out_oor_q;
  logic signed [OUT_W-1:0] out_temp_d, out_temp_q;
  logic                    sk_valid_d, sk_valid_q, sk_oor_d, sk_oor_q;
  logic signed [OUT_W-1:0] sk_temp_d, sk_temp_q;

  // whole pipeline moves while the skid register is free
  assign pipe_en    = !sk_valid_q;
  assign in_stall_o = sk_valid_q;
  assign res_push   = pipe_en && res_ctl.valid;

  pt_rtt_front #(
    .RES_FRAC_BITS(RES_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (in_valid_i),
    .resistance_i(resistance_i),
    .m_o         (m),
    .ctl_o       (front_ctl)
  );

  pt_rtt_sqrt u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (pipe_en),
    .m_i   (m),
    .ctl_i (front_ctl),
    .root_o(root),
    .ctl_o (sqrt_ctl)
  );

  pt_rtt_back #(
    .TEMP_FRAC_BITS(TEMP_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .root_i       (root),
    .ctl_i        (sqrt_ctl),
    .temperature_o(res_temp),
    .ctl_o        (res_ctl)
  );

  // output register with one skid word behind it
  always_comb begin
    out_valid_d = out_valid_q;
    out_temp_d  = out_temp_q;
    out_oor_d   = out_oor_q;
    sk_valid_d  = sk_valid_q;
    sk_temp_d   = sk_temp_q;
    sk_oor_d    = sk_oor_q;
    if (!out_valid_q || !out_stall_i) begin
      if (sk_valid_q) begin
        out_valid_d = 1'b1;
        out_temp_d  = sk_temp_q;
        out_oor_d   = sk_oor_q;
        sk_valid_d  = 1'b0;
      end else begin
        out_valid_d = res_push;
        out_temp_d  = res_temp;
        out_oor_d   = res_ctl.oor;
      end
    end else if (res_push) begin
      sk_valid_d = 1'b1;
      sk_temp_d  = res_temp;
      sk_oor_d   = res_ctl.oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_temp_q <= out_temp_d;
    out_oor_q  <= out_oor_d;
    sk_temp_q  <= sk_temp_d;
    sk_oor_q   <= sk_oor_d;
  end

  assign out_valid_o    = out_valid_q;
  assign temperature_o  = out_temp_q;
  assign out_of_range_o = out_oor_q;

  a_skid_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid word taken while output register was free");

  a_skid_behind_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> (temperature_o == '0))
    else $error("out of range word with nonzero temperature");

endmodule

[sim/pt100_checker.sv]
// Scoreboard for the Pt100 converter: watches both handshakes, predicts each reading.
// Depends on pt_rtt_pkg for the port widths and the default fixed-point formats.
module pt100_checker import pt_rtt_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [IN_W-1:0]         resistance_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [OUT_W-1:0] temperature_i,
  input  logic                    out_of_range_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int RF = DEF_RES_FRAC_BITS;
  localparam int TF = DEF_TEMP_FRAC_BITS;
  localparam int MAX_REPORTS = 10;

  // Curve terms scaled to integers: A*1e8, (A*1e8)^2, 4B*1e14, 2B*1e10
  localparam longint CVD_A      = 64'sd390802;
  localparam longint CVD_A_SQ   = 64'sd152726203204;
  localparam longint CVD_4B     = 64'sd232080000;
  localparam longint CVD_2B     = 64'sd11604;
  localparam longint SPAN_LO_MO = 64'sd20545;
  localparam longint SPAN_HI_MO = 64'sd390524;
  localparam int     RAD_FRAC   = 26;
  localparam int     ROOT_FB    = 13;

  typedef struct packed {
    logic signed [OUT_W-1:0] temp_c;
    logic                    oor;
  } reading_t;

  reading_t pending_readings[$];
  int       mismatches = 0;
  int       words_out = 0;

  function automatic reading_t convert_resistance(logic [IN_W-1:0] ohms_fx);
    reading_t          r;
    longint            x, lo_code, hi_code, disc, diff_n, den, mag, t;
    longint unsigned   rad, rest, root, probe;
    x       = longint'(ohms_fx);
    lo_code = (SPAN_LO_MO * (64'sd1 <<< RF) + 999) / 1000;
    hi_code = (SPAN_HI_MO * (64'sd1 <<< RF)) / 1000;
    if (x < lo_code || x > hi_code) begin
      r.temp_c = '0;
      r.oor    = 1'b1;
      return r;
    end
    disc = CVD_A_SQ * (64'sd1 <<< RF) + CVD_4B * (64'sd100 * (64'sd1 <<< RF) - x);
    if (disc < 0) disc = 0;
    rad = longint'(disc) << (RAD_FRAC - RF);
    // bitwise integer square root, one root bit per step
    rest  = rad;
    root  = 0;
    probe = 64'd1 << 62;
    repeat (32) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    diff_n = CVD_A * (64'sd1 <<< ROOT_FB) - longint'(root);
    den    = CVD_2B * (64'sd1 <<< ROOT_FB);
    mag    = (diff_n < 0) ? -diff_n : diff_n;
    mag    = (mag * 100 * (64'sd1 <<< TF) + den / 2) / den;
    t      = (diff_n < 0) ? -mag : mag;
    if (t > (64'sd1 <<< (OUT_W - 1)) - 1) t = (64'sd1 <<< (OUT_W - 1)) - 1;
    if (t < -(64'sd1 <<< (OUT_W - 1))) t = -(64'sd1 <<< (OUT_W - 1));
    r.temp_c = t[OUT_W-1:0];
    r.oor    = 1'b0;
    return r;
  endfunction

  function automatic void note_mismatch(string what, reading_t exp_r, reading_t got_r);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] word %0d %s: temperature exp %0d got %0d, out_of_range exp %0b got %0b",
               $time, words_out, what, exp_r.temp_c, got_r.temp_c, exp_r.oor, got_r.oor);
  endfunction

  always @(posedge clk_i) begin
    reading_t got_r, exp_r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        pending_readings.push_back(convert_resistance(resistance_i));
      if (out_valid_i && !out_stall_i) begin
        got_r.temp_c = temperature_i;
        got_r.oor    = out_of_range_i;
        if (pending_readings.size() == 0) begin
          exp_r = '0;
          note_mismatch("unexpected", exp_r, got_r);
        end else begin
          exp_r = pending_readings.pop_front();
          if (got_r.temp_c !== exp_r.temp_c || got_r.oor !== exp_r.oor)
            note_mismatch("mismatch", exp_r, got_r);
        end
        words_out++;
      end
    end
    pending_o    <= pending_readings.size();
    fail_count_o <= mismatches;
  end

endmodule

[sim/testbench.sv]
// Top of the Pt100 converter testbench: clock, reset, stimulus, flow control, verdict.
// Depends on pt_rtt_pkg, pt100_resistance_to_temperature_top and pt100_checker.
module testbench import pt_rtt_pkg::*;;

  localparam int RANDOM_WORDS = 700;
  localparam int CALM_TAIL    = 120;   // last words go without any idling
  localparam int HOLD_AT      = 250;   // long output hold-off starts here
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_AT     = 450;   // sender waits for an empty pipeline here
  localparam int IDLE_LIMIT   = 2000;
  localparam int END_PAD      = 60;

  // in-range span in codes for 10 fraction bits
  localparam logic [IN_W-1:0] SPAN_LO = 19'd21039;
  localparam logic [IN_W-1:0] SPAN_HI = 19'd399896;
  localparam logic [IN_W-1:0] ZERO_C  = 19'd102400;  // 100 ohm

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [IN_W-1:0]         resistance_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] temperature_o;
  logic                    out_of_range_o;

  int fail_count;
  int pending;
  int words_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_active = 1'b0;
  bit hold_done = 1'b0;

  pt100_resistance_to_temperature_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .resistance_i,
    .out_valid_o, .out_stall_i, .temperature_o, .out_of_range_o
  );

  pt100_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i     (in_stall_o),
    .resistance_i,
    .out_valid_i    (out_valid_o),
    .out_stall_i,
    .temperature_i  (temperature_o),
    .out_of_range_i (out_of_range_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT - 1) begin
        $display("** pt100_resistance_to_temperature_top: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(logic [IN_W-1:0] value);
    in_valid_i   <= 1'b1;
    resistance_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && !hold_active && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  function automatic logic [IN_W-1:0] pick_resistance();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return IN_W'($urandom_range(SPAN_LO, SPAN_HI));
    if (sel < 80) return IN_W'($urandom_range(SPAN_LO - 4, SPAN_LO + 4));
    if (sel < 88) return IN_W'($urandom_range(SPAN_HI - 4, SPAN_HI + 4));
    return IN_W'($urandom);
  endfunction

  // sender and verdict
  initial begin
    logic [IN_W-1:0] directed[$];
    directed = '{19'd0, 19'd1, SPAN_LO - 19'd1, SPAN_LO, SPAN_LO + 19'd1,
                 SPAN_HI - 19'd1, SPAN_HI, SPAN_HI + 19'd1, ZERO_C - 19'd1, ZERO_C,
                 ZERO_C + 19'd1, 19'd80000, 19'd138506, 19'd250000, 19'h2AAAA,
                 19'h55555, 19'h7FFFF, 19'h40000, 19'd21038, 19'd399897};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_word(directed[i]);
      maybe_gap();
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_TAIL) calm = 1'b1;
      if (words_sent == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_word(pick_resistance());
      maybe_gap();
    end
    calm = 1'b1;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (END_PAD) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("** pt100_resistance_to_temperature_top: PASSED **");
    else
      $display("** pt100_resistance_to_temperature_top: FAILED **");
    $finish;
  end

  // receiver flow control: alternating stall and run bursts, one long hold-off
  initial begin
    bit stall_last;
    stall_last = 1'b0;
    wait (rst_ni);
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!hold_done && words_sent >= HOLD_AT) begin
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
        hold_done   = 1'b1;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!stall_last && $urandom_range(0, 2) == 0) begin
        stall_last = 1'b1;
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        stall_last = 1'b0;
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

endmodule
